// ===== rtl/core/lpct_pkg.sv =====
package lpct_pkg;

	localparam int NUM_SENSORS = 5;
	localparam int SAMPLE_BITS = 10;
	localparam int FIELD_W     = 12;
	localparam int REG_W       = 60;
	localparam int CFG_IDX_W   = 1;

	// datapath widths, sized for 12-bit bias/gain and the sensor count above
	localparam int V_W   = 24;              // one weighted sample
	localparam int M_W   = 26;              // mass
	localparam int A_W   = 28;              // 2*torque - (N+1)*mass
	localparam int MM_W  = M_W - 1;         // |mass|
	localparam int DEN_W = 28;              // (N+1)*|mass|
	localparam int Q_W   = 16;              // quotient bits
	localparam int NUM_W = A_W - 1 + 15 + 1;
	localparam int HI_W  = NUM_W - Q_W;
	localparam int IDX_W = $clog2(NUM_SENSORS);
	localparam int WT_W  = 6;

	localparam logic [CFG_IDX_W-1:0] REG_BIAS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = 1'd1;

	localparam logic [REG_W-1:0] BIAS_RESET = 60'h0;
	localparam logic [REG_W-1:0] GAIN_RESET = 60'h0100100100100100;

	typedef enum logic [2:0] {
		MODE_UNDEF   = 3'd0,
		MODE_TRACK   = 3'd1,
		MODE_TRACK_R = 3'd2,
		MODE_TRACK_L = 3'd3,
		MODE_LOST_R  = 3'd4,
		MODE_LOST_L  = 3'd5,
		MODE_LOST    = 3'd6
	} mode_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample_4;
		logic [SAMPLE_BITS-1:0] sample_3;
		logic [SAMPLE_BITS-1:0] sample_2;
		logic [SAMPLE_BITS-1:0] sample_1;
		logic [SAMPLE_BITS-1:0] sample_0;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]         track_state;
		logic signed [15:0] vehicle_offset;
	} out_beat_t;

	typedef struct packed {
		logic           done;
		logic           ovf;
		logic [Q_W-1:0] quot;
	} div_rsp_t;

	// position weight of sensor i relative to center, doubled: 2(i+1) - (N+1)
	function automatic logic signed [WT_W-1:0] pos_weight(input logic [IDX_W-1:0] idx);
		logic signed [WT_W-1:0] w;
		w = WT_W'(2 * int'(idx) + 1 - NUM_SENSORS);
		return w;
	endfunction

endpackage

// ===== rtl/core/lpct_div.sv =====
module lpct_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lpct_pkg::HI_W-1:0]   num_hi,
	input  logic [lpct_pkg::Q_W-1:0]    num_lo,
	input  logic [lpct_pkg::DEN_W-1:0]  den,
	output lpct_pkg::div_rsp_t          rsp
);
	import lpct_pkg::*;

	localparam int CNT_W = $clog2(Q_W);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [Q_W-1:0]   lo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             ovf_q;

	logic [DEN_W:0]   trial;
	logic             fits;
	logic             ovf_now;

	// one restoring step per cycle
	assign trial = {rem_q, lo_q[Q_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	// quotient would need more than Q_W bits
	assign ovf_now = {{(DEN_W - HI_W){1'b0}}, num_hi} >= den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// one-cycle pulse; an overflowing quotient finishes at launch
			done_q <= start ? ovf_now : (busy_q && cnt_q == CNT_W'(Q_W - 1));
			if (start) begin
				den_q <= den;
				cnt_q <= '0;
				ovf_q <= ovf_now;
				if (!ovf_now) begin
					busy_q <= 1'b1;
					rem_q  <= DEN_W'(num_hi);
					lo_q   <= num_lo;
				end
			end else if (busy_q) begin
				rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
				lo_q  <= {lo_q[Q_W-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(Q_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.ovf  = ovf_q;
	assign rsp.quot = lo_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while busy");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < den_q))
		else $error("partial remainder not below divisor");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start)
		else $error("divider restarted while busy");

endmodule

// ===== rtl/core/line_position_centroid_tracker.sv =====
// channel  dir  handshake            payload
// in       in   in_valid/in_ready    in_beat_t: sample_0..sample_4
// out      out  out_valid/out_ready  out_beat_t: track_state, vehicle_offset
// cfg      in   cfg_we               cfg_index, cfg_data (no read-back)
//
// A beat is taken only while idle and is worked through before the next: each
// sensor takes a multiply and an add step through the shared multiplier, then
// the beat is classified, the divider is launched, runs its restoring steps and
// the quotient is collected, and the output register is loaded. Centered
// results skip the divider; a saturating quotient is flagged at launch.
// in_ready is high only while idle; the result sits in an output register,
// so the next beat can be taken while the previous result waits. The load
// into the output register stalls only while an older result is unaccepted.
// Reset clears mode to undefined, held offset to zero, gains to 1.0.
module line_position_centroid_tracker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  lpct_pkg::in_beat_t                in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output lpct_pkg::out_beat_t               out_data,
	input  logic                              cfg_we,
	input  logic [lpct_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lpct_pkg::REG_W-1:0]        cfg_data
);
	import lpct_pkg::*;

	localparam int EDGE_K = 2 * NUM_SENSORS - 3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ADD,
		S_CLASS,
		S_DIVGO,
		S_DIV,
		S_DONE
	} state_t;

	state_t                  state_q;
	logic [REG_W-1:0]        bias_q;
	logic [REG_W-1:0]        gain_q;
	in_beat_t                in_q;
	logic [IDX_W-1:0]        idx_q;
	logic signed [V_W-1:0]   v_q;
	logic signed [M_W-1:0]   mass_q;
	logic signed [A_W-1:0]   a_q;
	logic                    centered_q;
	logic                    right_q;
	logic                    left_q;
	logic                    an_neg_q;
	logic [HI_W-1:0]         num_hi_q;
	logic [Q_W-1:0]          num_lo_q;
	logic [DEN_W-1:0]        den_q;
	mode_t                   mode_q;
	logic signed [15:0]      held_q;
	logic                    out_valid_q;
	out_beat_t               out_q;

	logic [SAMPLE_BITS-1:0]  samp [NUM_SENSORS];
	logic [FIELD_W-1:0]      bias_f [NUM_SENSORS];
	logic [FIELD_W-1:0]      gain_f [NUM_SENSORS];

	logic signed [FIELD_W:0]       diff;
	logic signed [FIELD_W-1:0]     gain_s;
	logic signed [2*FIELD_W:0]     prod_v;
	logic signed [WT_W-1:0]        wt;
	logic signed [V_W+WT_W-1:0]    prod_a;

	logic                    mass_neg;
	logic [MM_W-1:0]         mm;
	logic signed [A_W-1:0]   an;
	logic [A_W-2:0]          abs_a;
	logic signed [A_W+1:0]   two_an;
	logic signed [A_W+1:0]   edge_mm;
	logic [DEN_W-1:0]        den_c;
	logic [NUM_W-1:0]        num_c;

	div_rsp_t                div_rsp;
	logic                    div_start;

	logic                    mag_big;
	logic                    mag_max;
	logic signed [15:0]      off;
	mode_t                   mode_nx;
	logic signed [15:0]      held_nx;
	logic                    out_free;

	always_comb begin
		samp[0] = in_q.sample_0;
		samp[1] = in_q.sample_1;
		samp[2] = in_q.sample_2;
		samp[3] = in_q.sample_3;
		samp[4] = in_q.sample_4;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			bias_f[i] = bias_q[FIELD_W*i +: FIELD_W];
			gain_f[i] = gain_q[FIELD_W*i +: FIELD_W];
		end
	end

	// shared multiplier: (sample - bias) * gain
	assign diff   = $signed({{(FIELD_W + 1 - SAMPLE_BITS){1'b0}}, samp[idx_q]})
	              - $signed({bias_f[idx_q][FIELD_W-1], bias_f[idx_q]});
	assign gain_s = $signed(gain_f[idx_q]);
	assign prod_v = diff * gain_s;
	assign wt     = pos_weight(idx_q);
	assign prod_a = v_q * wt;

	// classification on sign-normalized values
	assign mass_neg = mass_q[M_W-1];
	assign mm       = mass_neg ? MM_W'(-mass_q) : MM_W'(mass_q);
	assign an       = mass_neg ? -a_q : a_q;
	assign abs_a    = a_q[A_W-1] ? (A_W-1)'(-a_q) : (A_W-1)'(a_q);
	assign two_an   = {an[A_W-1], an, 1'b0};
	assign edge_mm  = $signed((A_W + 2)'(mm) * (A_W + 2)'(EDGE_K));
	assign den_c    = DEN_W'(mm * (NUM_SENSORS + 1));
	assign num_c    = {1'b0, abs_a, 15'b0} + NUM_W'(den_c >> 1);

	assign div_start = (state_q == S_DIVGO);

	lpct_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_hi (num_hi_q),
		.num_lo (num_lo_q),
		.den    (den_q),
		.rsp    (div_rsp)
	);

	// round-half-away magnitude from divider, then sign and saturate
	assign mag_big = div_rsp.ovf || div_rsp.quot[Q_W-1];
	assign mag_max = mag_big || (div_rsp.quot == 16'h7FFF);
	always_comb begin
		if (!an_neg_q)
			off = mag_big ? -16'sd32768 : -$signed(div_rsp.quot);
		else
			off = mag_max ? 16'sd32767 : $signed(div_rsp.quot);
	end

	always_comb begin
		mode_nx = mode_q;
		held_nx = held_q;
		if (centered_q) begin
			case (mode_q)
				MODE_LOST_R, MODE_LOST_L, MODE_LOST: begin
				end
				MODE_TRACK_R: begin
					mode_nx = MODE_LOST_R;
					held_nx = -16'sd32768;
				end
				MODE_TRACK_L: begin
					mode_nx = MODE_LOST_L;
					held_nx = 16'sd32767;
				end
				default: begin
					mode_nx = MODE_LOST;
					held_nx = 16'sd0;
				end
			endcase
		end else begin
			held_nx = off;
			if (right_q)
				mode_nx = MODE_TRACK_R;
			else if (left_q)
				mode_nx = MODE_TRACK_L;
			else
				mode_nx = MODE_TRACK;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bias_q      <= BIAS_RESET;
			gain_q      <= GAIN_RESET;
			mode_q      <= MODE_UNDEF;
			held_q      <= '0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BIAS: bias_q <= cfg_data;
					REG_GAIN: gain_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						in_q    <= in_data;
						idx_q   <= '0;
						mass_q  <= '0;
						a_q     <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					v_q     <= V_W'(prod_v);
					state_q <= S_ADD;
				end
				S_ADD: begin
					mass_q <= mass_q + M_W'(v_q);
					a_q    <= a_q + A_W'(prod_a);
					if (idx_q == IDX_W'(NUM_SENSORS - 1)) begin
						state_q <= S_CLASS;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_MUL;
					end
				end
				S_CLASS: begin
					centered_q <= (mass_q == '0) || ({1'b0, abs_a, 1'b0} < (A_W + 1)'(mm));
					right_q    <= two_an >= edge_mm;
					left_q     <= two_an <= -edge_mm;
					an_neg_q   <= an[A_W-1];
					num_hi_q   <= num_c[NUM_W-1:Q_W];
					num_lo_q   <= num_c[Q_W-1:0];
					den_q      <= den_c;
					if ((mass_q == '0) || ({1'b0, abs_a, 1'b0} < (A_W + 1)'(mm)))
						state_q <= S_DONE;
					else
						state_q <= S_DIVGO;
				end
				S_DIVGO: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						held_q  <= off;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						mode_q               <= mode_nx;
						held_q               <= held_nx;
						out_q.track_state    <= mode_nx;
						out_q.vehicle_offset <= held_nx;
						state_q              <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_div_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && div_rsp.done) |=> (state_q == S_DONE))
		else $error("divider result not picked up");

	a_no_undef_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.track_state != MODE_UNDEF))
		else $error("result carries undefined mode");

	a_lost_right_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.track_state == MODE_LOST_R)
			|-> (out_q.vehicle_offset == -16'sd32768))
		else $error("lost right without full negative offset");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL || state_q == S_ADD) |-> (idx_q < IDX_W'(NUM_SENSORS)))
		else $error("sensor index out of range");

endmodule
